// ===== hdl/aec_pkg.sv =====
// Shared types and constants of the audio environment classifier.
package aec_pkg;

    // Window of recent levels; the depth is a power of two so the mean is a shift.
    localparam int WIN_DEPTH = 8;
    localparam int WIN_LOG2  = $clog2(WIN_DEPTH);

    localparam int LEVEL_W = 16;
    localparam int SQ_W    = 2 * LEVEL_W;
    localparam int SUM_W   = LEVEL_W + WIN_LOG2;
    localparam int SQSUM_W = SQ_W + WIN_LOG2;

    // Scaled variance numerator N*Q - S*S.
    localparam int NUM_W   = 2 * SUM_W;
    // The numerator divided by N*N stays below 16384 * 65535, which fits in 30 bits.
    localparam int T_W     = 30;
    localparam int VAR_W   = 15;
    localparam int CONF_W  = 8;

    localparam logic [LEVEL_W-1:0] FULL_SCALE = 16'd65535;

    typedef enum logic [2:0] {
        CLS_UNKNOWN  = 3'd0,
        CLS_QUIET    = 3'd1,
        CLS_AMBIENT  = 3'd2,
        CLS_MODERATE = 3'd3,
        CLS_LOUD     = 3'd4,
        CLS_CONCERT  = 3'd5,
        CLS_EXTREME  = 3'd6
    } env_class_t;

    localparam logic [CONF_W-1:0] CONF_LIMIT_RESET = 8'd100;

endpackage

// ===== hdl/aec_window.sv =====
// Shift line of recent levels with running sum, running sum of squares and peak.
module aec_window
    import aec_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [LEVEL_W-1:0] wr_level,
    output logic [SUM_W-1:0]   sum,
    output logic [SQSUM_W-1:0] sqsum,
    output logic [LEVEL_W-1:0] peak
);

    logic [LEVEL_W-1:0] hist_reg [WIN_DEPTH];
    logic [SQ_W-1:0]    sq_reg   [WIN_DEPTH];
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [SQSUM_W-1:0] sqsum_reg;
    logic [SQSUM_W-1:0] sqsum_next;
    logic [SQ_W-1:0]    sq_new;
    logic [LEVEL_W-1:0] max_tree [1:2*WIN_DEPTH-1];

    // The oldest entry leaves at the end of the line as the new one enters.
    assign sq_new     = SQ_W'(wr_level) * SQ_W'(wr_level);
    assign sum_next   = sum_reg + SUM_W'(wr_level) - SUM_W'(hist_reg[WIN_DEPTH-1]);
    assign sqsum_next = sqsum_reg + SQSUM_W'(sq_new) - SQSUM_W'(sq_reg[WIN_DEPTH-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
                sq_reg[i]   <= '0;
            end
            sum_reg   <= '0;
            sqsum_reg <= '0;
        end
        else if (wr_en)
        begin
            hist_reg[0] <= wr_level;
            sq_reg[0]   <= sq_new;
            for (int i = 1; i < WIN_DEPTH; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
                sq_reg[i]   <= sq_reg[i-1];
            end
            sum_reg   <= sum_next;
            sqsum_reg <= sqsum_next;
        end
    end

    // Peak as a balanced compare tree whose leaves are the stored entries.
    always_comb
    begin
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            max_tree[WIN_DEPTH+i] = hist_reg[i];
        end
        for (int i = WIN_DEPTH-1; i >= 1; i--)
        begin
            max_tree[i] = (max_tree[2*i] > max_tree[2*i+1]) ? max_tree[2*i] : max_tree[2*i+1];
        end
        peak = max_tree[1];
    end

    assign sum   = sum_reg;
    assign sqsum = sqsum_reg;

endmodule

// ===== hdl/aec_tracker.sv =====
// Noise floor tracking, class selection and confidence hysteresis.
module aec_tracker
    import aec_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               upd_en,
    input  logic [LEVEL_W-1:0] mean,
    input  logic [LEVEL_W-1:0] peak,
    input  logic [VAR_W-1:0]   var_in,
    input  logic [CONF_W-1:0]  limit,
    output env_class_t         held_class,
    output logic [CONF_W-1:0]  confidence,
    output logic [LEVEL_W-1:0] noise_floor
);

    localparam logic [LEVEL_W-1:0] TH_MEAN_QUIET    = 16'd6554;
    localparam logic [LEVEL_W-1:0] TH_MEAN_AMBIENT  = 16'd16384;
    localparam logic [LEVEL_W-1:0] TH_MEAN_MODERATE = 16'd32768;
    localparam logic [LEVEL_W-1:0] TH_MEAN_LOUD     = 16'd49151;
    localparam logic [LEVEL_W-1:0] TH_PEAK_LOUD     = 16'd52428;
    localparam logic [LEVEL_W-1:0] TH_MEAN_EXTREME  = 16'd58982;
    localparam logic [VAR_W-1:0]   TH_VAR_QUIET     = 15'd655;
    localparam logic [VAR_W-1:0]   TH_VAR_AMBIENT   = 15'd3277;
    localparam logic [VAR_W-1:0]   TH_VAR_MODERATE  = 15'd9830;
    localparam logic [VAR_W-1:0]   TH_VAR_LOUD      = 15'd13107;
    localparam logic [VAR_W-1:0]   TH_VAR_CONCERT   = 15'd19661;

    // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x below 91180, which
    // covers every divider input here (at most 65535 + 99).
    localparam int                 DIV_W       = LEVEL_W + 1;
    localparam int                 PROD_W      = 2 * DIV_W;
    localparam int                 RECIP_SHIFT = 23;
    localparam logic [DIV_W-1:0]   RECIP_100   = 17'd83887;
    localparam logic [DIV_W-1:0]   ROUND_UP_99 = 17'd99;

    env_class_t         class_reg;
    env_class_t         class_next;
    env_class_t         pick;
    logic [CONF_W-1:0]  conf_reg;
    logic [CONF_W-1:0]  conf_next;
    logic [CONF_W:0]    conf_inc;
    logic [LEVEL_W-1:0] floor_reg;
    logic [LEVEL_W-1:0] floor_next;
    logic               floor_zero;
    logic               floor_move;
    logic [DIV_W-1:0]   div_in;
    logic [PROD_W-1:0]  div_prod;
    logic [LEVEL_W-1:0] div_q;

    // The floor moves 1% down toward the mean, or up from zero. Below it, 99f + m
    // over 100 is f minus the distance over 100 rounded up, so one divide serves.
    assign floor_zero = (floor_reg == '0);
    assign floor_move = (mean < floor_reg) || floor_zero;
    assign div_in     = floor_zero ? DIV_W'(mean)
                                   : (DIV_W'(floor_reg) - DIV_W'(mean) + ROUND_UP_99);
    assign div_prod   = PROD_W'(div_in) * PROD_W'(RECIP_100);
    assign div_q      = LEVEL_W'(div_prod >> RECIP_SHIFT);

    always_comb
    begin
        if (!floor_move)
        begin
            floor_next = floor_reg;
        end
        else if (floor_zero)
        begin
            floor_next = div_q;
        end
        else
        begin
            floor_next = floor_reg - div_q;
        end
    end

    // Threshold cascade; the first matching rule wins.
    always_comb
    begin
        priority if (mean < TH_MEAN_QUIET && var_in < TH_VAR_QUIET)
        begin
            pick = CLS_QUIET;
        end
        else if (mean < TH_MEAN_AMBIENT && var_in < TH_VAR_AMBIENT)
        begin
            pick = CLS_AMBIENT;
        end
        else if (mean < TH_MEAN_MODERATE && var_in < TH_VAR_MODERATE)
        begin
            pick = CLS_MODERATE;
        end
        else if (mean < TH_MEAN_LOUD || (var_in > TH_VAR_LOUD && peak > TH_PEAK_LOUD))
        begin
            pick = CLS_LOUD;
        end
        else if (mean > TH_MEAN_LOUD && var_in > TH_VAR_CONCERT)
        begin
            pick = CLS_CONCERT;
        end
        else if (mean > TH_MEAN_EXTREME)
        begin
            pick = CLS_EXTREME;
        end
        else
        begin
            pick = CLS_UNKNOWN;
        end
    end

    // The count must drain to zero before a different class is taken over.
    assign conf_inc = {1'b0, conf_reg} + 1'b1;

    always_comb
    begin
        class_next = class_reg;
        priority if (pick == class_reg)
        begin
            conf_next = (conf_inc < {1'b0, limit}) ? conf_inc[CONF_W-1:0] : limit;
        end
        else if (conf_reg != '0)
        begin
            conf_next = conf_reg - 1'b1;
        end
        else
        begin
            class_next = pick;
            conf_next  = CONF_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_reg <= CLS_UNKNOWN;
            conf_reg  <= '0;
            floor_reg <= '0;
        end
        else if (upd_en)
        begin
            class_reg <= class_next;
            conf_reg  <= conf_next;
            floor_reg <= floor_next;
        end
    end

    assign held_class  = class_reg;
    assign confidence  = conf_reg;
    assign noise_floor = floor_reg;

endmodule

// ===== hdl/audio_environment_classifier.sv =====
// Top level of the audio environment classifier: window statistics pipeline and result register.
//
// The block takes one normalized level per item (unsigned Q0.16) and returns one result per
// item: the held loudness class, its confidence count, and the mean, peak, population variance
// and tracked noise floor of the last eight levels. It accepts a new item in every cycle while
// in_stall is low. An accepted item passes six registers in order: an input register, the
// window shift line with its running sums, a stage holding the squared sum, a stage forming
// the variance numerator, a stage dividing it by full scale, and the result register, whose
// load also updates the noise floor, the held class and the confidence count. The sustained
// rate is set by the result register alone: whenever the output is not stalled, one item
// leaves per cycle, and stages fill up behind a stalled result before in_stall is raised.
// After reset the history, the floor and the count are zero and the class is unknown. The
// single configuration register, limit_reg, resets to 100; the user must write it through
// cfg_data only while the block is idle, as the block itself does not enforce this.
// cfg_ready is always high.
module audio_environment_classifier
    import aec_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        level,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         env_class,
    output logic [7:0]         confidence,
    output logic [15:0]        window_mean,
    output logic [15:0]        window_peak,
    output logic [14:0]        window_variance,
    output logic [15:0]        noise_floor,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data
);

    // Stage valid flags. Stage 1 is the window itself.
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, vout_reg;
    logic en0, en1, en2, en3, en4, en_out;

    logic [CONF_W-1:0]  limit_reg;

    logic [LEVEL_W-1:0] lvl_reg;

    logic [SUM_W-1:0]   win_sum;
    logic [SQSUM_W-1:0] win_sqsum;
    logic [LEVEL_W-1:0] win_peak;

    logic [NUM_W-1:0]   s2_ssq_reg;
    logic [NUM_W-1:0]   s2_q8_reg;
    logic [LEVEL_W-1:0] s2_mean_reg;
    logic [LEVEL_W-1:0] s2_peak_reg;

    logic [NUM_W-1:0]   num;
    logic [T_W-1:0]     s3_t_reg;
    logic [LEVEL_W-1:0] s3_mean_reg;
    logic [LEVEL_W-1:0] s3_peak_reg;

    logic [T_W-LEVEL_W-1:0] div_q;
    logic [LEVEL_W:0]       div_r;
    logic                   div_fix;
    logic [VAR_W-1:0]       var_next;
    logic [VAR_W-1:0]       s4_var_reg;
    logic [LEVEL_W-1:0]     s4_mean_reg;
    logic [LEVEL_W-1:0]     s4_peak_reg;

    logic [VAR_W-1:0]   out_var_reg;
    logic [LEVEL_W-1:0] out_mean_reg;
    logic [LEVEL_W-1:0] out_peak_reg;

    env_class_t         trk_class;
    logic               trk_upd;

    // A stage may load when it is empty or its content moves on in the same cycle.
    assign en_out   = !vout_reg || !out_stall;
    assign en4      = !v4_reg || en_out;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign en0      = !v0_reg || en1;
    assign in_stall = !en0;
    assign trk_upd  = en_out && v4_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= CONF_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else
        begin
            if (en0)
            begin
                v0_reg <= in_valid;
            end
            if (en1)
            begin
                v1_reg <= v0_reg;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en_out)
            begin
                vout_reg <= v4_reg;
            end
        end
    end

    // Stage 1: the level enters the window and the running sums follow it.
    aec_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (en1 && v0_reg),
        .wr_level (lvl_reg),
        .sum      (win_sum),
        .sqsum    (win_sqsum),
        .peak     (win_peak)
    );

    // Stage 3: N*Q - S*S is never negative; dividing by N*N is a shift.
    assign num = s2_q8_reg - s2_ssq_reg;

    // Stage 4: divide by 65535. With t = 65536*q + low, t - 65535*q = low + q,
    // which is below twice the divisor, so one correction step finishes it.
    assign div_q    = s3_t_reg[T_W-1:LEVEL_W];
    assign div_r    = {1'b0, s3_t_reg[LEVEL_W-1:0]} + (LEVEL_W+1)'(div_q);
    assign div_fix  = (div_r >= {1'b0, FULL_SCALE});
    assign var_next = VAR_W'(div_q) + VAR_W'(div_fix);

    always_ff @(posedge clk)
    begin
        if (en0 && in_valid)
        begin
            lvl_reg <= level;
        end
        if (en2 && v1_reg)
        begin
            s2_ssq_reg  <= NUM_W'(win_sum) * NUM_W'(win_sum);
            s2_q8_reg   <= NUM_W'(win_sqsum) << WIN_LOG2;
            s2_mean_reg <= win_sum[SUM_W-1:WIN_LOG2];
            s2_peak_reg <= win_peak;
        end
        if (en3 && v2_reg)
        begin
            s3_t_reg    <= T_W'(num >> (2 * WIN_LOG2));
            s3_mean_reg <= s2_mean_reg;
            s3_peak_reg <= s2_peak_reg;
        end
        if (en4 && v3_reg)
        begin
            s4_var_reg  <= var_next;
            s4_mean_reg <= s3_mean_reg;
            s4_peak_reg <= s3_peak_reg;
        end
        if (trk_upd)
        begin
            out_var_reg  <= s4_var_reg;
            out_mean_reg <= s4_mean_reg;
            out_peak_reg <= s4_peak_reg;
        end
    end

    // Result stage: the floor, class and count registers load together with the result.
    aec_tracker u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd_en      (trk_upd),
        .mean        (s4_mean_reg),
        .peak        (s4_peak_reg),
        .var_in      (s4_var_reg),
        .limit       (limit_reg),
        .held_class  (trk_class),
        .confidence  (confidence),
        .noise_floor (noise_floor)
    );

    assign out_valid       = vout_reg;
    assign env_class       = trk_class;
    assign window_mean     = out_mean_reg;
    assign window_peak     = out_peak_reg;
    assign window_variance = out_var_reg;

endmodule
